// ===== src/fpts_pkg.sv =====
// ============================================================================
// fpts_pkg
// Shared types and codes for the fixed-priority task scheduler.
// ============================================================================
package fpts_pkg;

    localparam int unsigned PRIO_W    = 8;
    localparam int unsigned CNT_W     = 16;
    localparam int unsigned CFG_W     = 64;
    localparam int unsigned ADDR_W    = 5;
    localparam logic [PRIO_W-1:0] WORST_PRIO = 8'd255;

    // event codes on the input channel
    typedef enum logic [2:0] {
        OP_TICK    = 3'd0,
        OP_YIELD   = 3'd1,
        OP_SUSPEND = 3'd2,
        OP_KILL    = 3'd3,
        OP_TRYLOCK = 3'd4,
        OP_LOCK    = 3'd5,
        OP_UNLOCK  = 3'd6,
        OP_START   = 3'd7
    } op_t;

    typedef enum logic [2:0] {
        TS_READY   = 3'd0,
        TS_RUNNING = 3'd1,
        TS_WAITING = 3'd2,
        TS_DONE    = 3'd3,
        TS_DEAD    = 3'd4
    } task_state_t;

    // what the per-entry walk does to each task entry
    typedef enum logic [2:0] {
        WM_TICK    = 3'd0,
        WM_YIELD   = 3'd1,
        WM_SUSPEND = 3'd2,
        WM_KILL    = 3'd3,
        WM_BLOCK   = 3'd4,
        WM_START   = 3'd5
    } walk_mode_t;

    typedef enum logic [1:0] {
        FSM_IDLE   = 2'd0,
        FSM_WALK   = 2'd1,
        FSM_COMMIT = 2'd2,
        FSM_DONE   = 2'd3
    } fsm_t;

    typedef enum logic [1:0] {
        REG_ACTIVE_TASKS = 2'd0,
        REG_PRIORITIES   = 2'd1,
        REG_PERIODS      = 2'd2,
        REG_START_DELAYS = 2'd3
    } reg_addr_t;

    typedef struct packed {
        logic [2:0]       active_tasks;
        logic [31:0]      task_priorities;
        logic [CFG_W-1:0] task_periods;
        logic [CFG_W-1:0] task_start_delays;
    } cfg_t;

    typedef struct packed {
        walk_mode_t mode;
        logic       is_cur;
        logic       in_range;
    } step_ctl_t;

endpackage

// ===== src/fpts_cfg.sv =====
// ============================================================================
// fpts_cfg
// APB register file: task count, priorities, periods and start delays.
// ============================================================================
module fpts_cfg (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [fpts_pkg::ADDR_W-1:0]   paddr,
    input  logic [fpts_pkg::CFG_W-1:0]    pwdata,
    output logic [fpts_pkg::CFG_W-1:0]    prdata,
    output logic                          pready,
    output fpts_pkg::cfg_t                cfg
);
    import fpts_pkg::*;

    cfg_t      cfg_reg;
    reg_addr_t sel;
    logic      wr;

    assign pready = 1'b1;
    assign sel    = reg_addr_t'(paddr[4:3]);
    assign wr     = psel & penable & pwrite;
    assign cfg    = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.active_tasks      <= 3'd1;
            cfg_reg.task_priorities   <= '1;
            cfg_reg.task_periods      <= '0;
            cfg_reg.task_start_delays <= '0;
        end else if (wr) begin
            case (sel)
                REG_ACTIVE_TASKS: cfg_reg.active_tasks      <= pwdata[2:0];
                REG_PRIORITIES:   cfg_reg.task_priorities   <= pwdata[31:0];
                REG_PERIODS:      cfg_reg.task_periods      <= pwdata;
                REG_START_DELAYS: cfg_reg.task_start_delays <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (sel)
            REG_ACTIVE_TASKS: prdata = CFG_W'(cfg_reg.active_tasks);
            REG_PRIORITIES:   prdata = CFG_W'(cfg_reg.task_priorities);
            REG_PERIODS:      prdata = cfg_reg.task_periods;
            REG_START_DELAYS: prdata = cfg_reg.task_start_delays;
            default:          prdata = '0;
        endcase
    end

endmodule

// ===== src/fpts_step.sv =====
// ============================================================================
// fpts_step
// Per-entry unit: updates one task entry and compares it against the best.
// ============================================================================
module fpts_step #(
    parameter int unsigned MW = 8
) (
    input  fpts_pkg::step_ctl_t            ctl,
    input  fpts_pkg::task_state_t          state_in,
    input  logic [fpts_pkg::CNT_W-1:0]     cd_in,
    input  logic [MW-1:0]                  wm_in,
    input  logic [fpts_pkg::PRIO_W-1:0]    prio,
    input  logic [fpts_pkg::CNT_W-1:0]     period,
    input  logic [fpts_pkg::CNT_W-1:0]     delay,
    input  logic [MW-1:0]                  lock,
    input  logic [MW-1:0]                  mbit,
    input  logic [fpts_pkg::PRIO_W-1:0]    best_pr,
    output fpts_pkg::task_state_t          state_out,
    output logic [fpts_pkg::CNT_W-1:0]     cd_out,
    output logic [MW-1:0]                  wm_out,
    output logic                           cand
);
    import fpts_pkg::*;

    always_comb begin
        state_out = state_in;
        cd_out    = cd_in;
        wm_out    = wm_in;
        case (ctl.mode)
            WM_TICK: begin
                if (ctl.in_range && state_in != TS_DEAD) begin
                    if (cd_in == '0) begin
                        state_out = TS_READY;
                        cd_out    = period;
                    end
                    if (cd_out != '0) begin
                        cd_out = cd_out - CNT_W'(1);
                    end
                end
            end
            WM_YIELD:   if (ctl.is_cur) state_out = TS_WAITING;
            WM_SUSPEND: if (ctl.is_cur) state_out = TS_DONE;
            WM_KILL:    if (ctl.is_cur) state_out = TS_DEAD;
            WM_BLOCK: begin
                if (ctl.is_cur) begin
                    wm_out    = wm_in | mbit;
                    state_out = TS_WAITING;
                end
            end
            WM_START: begin
                cd_out    = delay;
                state_out = TS_DONE;
                wm_out    = '0;
            end
            default: ;
        endcase
        // running task steps aside before selection
        if (ctl.mode != WM_START && ctl.is_cur && state_out == TS_RUNNING) begin
            state_out = TS_WAITING;
        end
        cand = (ctl.mode != WM_START) && ctl.in_range &&
               (state_out == TS_READY || state_out == TS_WAITING) &&
               ((wm_out & lock) == '0) && (prio <= best_pr);
    end

endmodule

// ===== src/fixed_priority_task_scheduler_unit.sv =====
// ============================================================================
// fixed_priority_task_scheduler_unit
// Fixed-priority preemptive task scheduler with mutex bits.
// ============================================================================
// Tick, yield, suspend, kill and a blocking lock walk the task table, commit
// the chosen task and then load the result; start walks the table and loads
// the result with no commit; trylock, unlock and a granted or rejected lock
// load the result without a walk. One item at a time: a new item is accepted
// once the previous result is loaded, so the walk of the shared per-entry unit
// over the task table holds off the next item. Synchronous active-low reset:
// all tasks done, locks free, task 0 current, registers at their reset values.
module fixed_priority_task_scheduler_unit #(
    parameter int unsigned TASKS   = 4,
    parameter int unsigned MUTEXES = 8
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [fpts_pkg::ADDR_W-1:0]   paddr,
    input  logic [fpts_pkg::CFG_W-1:0]    pwdata,
    output logic [fpts_pkg::CFG_W-1:0]    prdata,
    output logic                          pready,
    // event channel
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [2:0]                    s_op,
    input  logic [7:0]                    s_mutex_index,
    // result channel
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [1:0]                    m_running_task,
    output logic                          m_granted,
    output logic [7:0]                    m_mutexes_held
);
    import fpts_pkg::*;

    localparam int unsigned IW  = (TASKS > 1) ? $clog2(TASKS) : 1;
    localparam int unsigned MW  = MUTEXES;
    localparam int unsigned MIW = (MUTEXES > 1) ? $clog2(MUTEXES) : 1;
    localparam logic [4:0] TASK_CNT  = 5'(TASKS);
    localparam logic [4:0] TASK_LAST = 5'(TASKS - 1);
    localparam logic [7:0] MUTEX_CNT = 8'(MUTEXES);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    cfg_t cfg;

    fpts_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // ------------------------------------------------------------------
    // State: task table (one access per cycle), locks, sequencer
    // ------------------------------------------------------------------
    task_state_t       ts_reg [TASKS];
    logic [CNT_W-1:0]  cd_reg [TASKS];
    logic [MW-1:0]     wm_reg [TASKS];

    fsm_t              fsm_reg, fsm_next;
    walk_mode_t        mode_reg, mode_next;
    logic [IW-1:0]     walk_idx_reg, walk_idx_next;
    logic [IW-1:0]     best_reg, best_next;
    logic [PRIO_W-1:0] best_pr_reg, best_pr_next;
    logic [MW-1:0]     bit_reg, bit_next;
    logic              granted_reg, granted_next;
    logic [MW-1:0]     lock_reg, lock_next;
    logic [IW-1:0]     cur_reg, cur_next;

    logic              m_valid_reg, m_valid_next;
    logic [1:0]        m_running_task_reg, m_running_task_next;
    logic              m_granted_reg, m_granted_next;
    logic [7:0]        m_mutexes_held_reg, m_mutexes_held_next;

    // ------------------------------------------------------------------
    // Event decode at acceptance
    // ------------------------------------------------------------------
    op_t           op;
    logic          acc;
    logic          idx_valid;
    logic [MW-1:0] in_bit;
    logic          held;
    logic          dec_walk;
    walk_mode_t    dec_mode;
    logic          dec_grant;
    logic          dec_wm_clear;
    logic [MW-1:0] dec_lock;

    assign s_ready   = (fsm_reg == FSM_IDLE);
    assign acc       = s_valid & s_ready;
    assign op        = op_t'(s_op);
    assign idx_valid = s_mutex_index < MUTEX_CNT;
    assign in_bit    = idx_valid ? (MW'(1) << s_mutex_index[MIW-1:0]) : '0;
    assign held      = |(lock_reg & in_bit);

    always_comb begin
        dec_walk     = 1'b0;
        dec_mode     = WM_TICK;
        dec_grant    = 1'b0;
        dec_wm_clear = 1'b0;
        dec_lock     = lock_reg;
        case (op)
            OP_TICK:    begin dec_walk = 1'b1; dec_mode = WM_TICK;    end
            OP_YIELD:   begin dec_walk = 1'b1; dec_mode = WM_YIELD;   end
            OP_SUSPEND: begin dec_walk = 1'b1; dec_mode = WM_SUSPEND; end
            OP_KILL:    begin dec_walk = 1'b1; dec_mode = WM_KILL;    end
            OP_TRYLOCK: begin
                if (idx_valid && !held) begin
                    dec_lock  = lock_reg | in_bit;
                    dec_grant = 1'b1;
                end
            end
            OP_LOCK: begin
                if (idx_valid) begin
                    if (held) begin
                        // blocked: walk parks the current task and reschedules
                        dec_walk = 1'b1;
                        dec_mode = WM_BLOCK;
                    end else begin
                        dec_lock     = lock_reg | in_bit;
                        dec_grant    = 1'b1;
                        dec_wm_clear = 1'b1;
                    end
                end
            end
            OP_UNLOCK: begin
                if (idx_valid) dec_lock = lock_reg & ~in_bit;
            end
            OP_START: begin
                dec_walk = 1'b1;
                dec_mode = WM_START;
                dec_lock = '0;
            end
            default: ;
        endcase
    end

    // ------------------------------------------------------------------
    // Table port: address follows the sequencer phase
    // ------------------------------------------------------------------
    logic [IW-1:0]     tbl_addr;
    task_state_t       rd_state;
    logic [CNT_W-1:0]  rd_cd;
    logic [MW-1:0]     rd_wm;

    always_comb begin
        case (fsm_reg)
            FSM_WALK:   tbl_addr = walk_idx_reg;
            FSM_COMMIT: tbl_addr = best_reg;
            default:    tbl_addr = cur_reg;
        endcase
    end

    assign rd_state = ts_reg[tbl_addr];
    assign rd_cd    = cd_reg[tbl_addr];
    assign rd_wm    = wm_reg[tbl_addr];

    // per-task configuration fields for the walked entry; entries past the
    // packed registers see worst priority and zero counts
    logic [4:0]        idx_ext;
    logic [4:0]        task_lim;
    logic              packed_ok;
    logic [PRIO_W-1:0] w_prio;
    logic [CNT_W-1:0]  w_period;
    logic [CNT_W-1:0]  w_delay;

    assign idx_ext   = 5'(walk_idx_reg);
    assign task_lim  = (5'(cfg.active_tasks) > TASK_CNT) ? TASK_CNT
                                                          : 5'(cfg.active_tasks);
    assign packed_ok = idx_ext < 5'd4;
    assign w_prio    = packed_ok ? cfg.task_priorities[idx_ext[1:0]*PRIO_W +: PRIO_W]
                                 : WORST_PRIO;
    assign w_period  = packed_ok ? cfg.task_periods[idx_ext[1:0]*CNT_W +: CNT_W] : '0;
    assign w_delay   = packed_ok ? cfg.task_start_delays[idx_ext[1:0]*CNT_W +: CNT_W]
                                 : '0;

    // ------------------------------------------------------------------
    // Shared per-entry unit
    // ------------------------------------------------------------------
    step_ctl_t         step_ctl;
    task_state_t       st_state;
    logic [CNT_W-1:0]  st_cd;
    logic [MW-1:0]     st_wm;
    logic              st_cand;

    assign step_ctl.mode     = mode_reg;
    assign step_ctl.is_cur   = (walk_idx_reg == cur_reg);
    assign step_ctl.in_range = idx_ext < task_lim;

    fpts_step #(.MW(MW)) u_step (
        .ctl       (step_ctl),
        .state_in  (rd_state),
        .cd_in     (rd_cd),
        .wm_in     (rd_wm),
        .prio      (w_prio),
        .period    (w_period),
        .delay     (w_delay),
        .lock      (lock_reg),
        .mbit      (bit_reg),
        .best_pr   (best_pr_reg),
        .state_out (st_state),
        .cd_out    (st_cd),
        .wm_out    (st_wm),
        .cand      (st_cand)
    );

    logic walk_last;
    logic out_free;

    assign walk_last = (idx_ext == TASK_LAST);
    assign out_free  = !m_valid_reg || m_ready;

    // ------------------------------------------------------------------
    // Next-state logic
    // ------------------------------------------------------------------
    always_comb begin
        fsm_next = fsm_reg;
        case (fsm_reg)
            FSM_IDLE: begin
                if (acc) fsm_next = dec_walk ? FSM_WALK : FSM_DONE;
            end
            FSM_WALK: begin
                if (walk_last) fsm_next = (mode_reg == WM_START) ? FSM_DONE : FSM_COMMIT;
            end
            FSM_COMMIT: fsm_next = FSM_DONE;
            FSM_DONE: begin
                if (out_free) fsm_next = FSM_IDLE;
            end
            default: fsm_next = FSM_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Datapath / output logic
    // ------------------------------------------------------------------
    logic              tbl_we_state, tbl_we_cd, tbl_we_wm;
    task_state_t       wr_state;
    logic [CNT_W-1:0]  wr_cd;
    logic [MW-1:0]     wr_wm;

    always_comb begin
        mode_next           = mode_reg;
        walk_idx_next       = walk_idx_reg;
        best_next           = best_reg;
        best_pr_next        = best_pr_reg;
        bit_next            = bit_reg;
        granted_next        = granted_reg;
        lock_next           = lock_reg;
        cur_next            = cur_reg;
        m_valid_next        = m_valid_reg && !m_ready;
        m_running_task_next = m_running_task_reg;
        m_granted_next      = m_granted_reg;
        m_mutexes_held_next = m_mutexes_held_reg;
        tbl_we_state        = 1'b0;
        tbl_we_cd           = 1'b0;
        tbl_we_wm           = 1'b0;
        wr_state            = st_state;
        wr_cd               = st_cd;
        wr_wm               = st_wm;
        case (fsm_reg)
            FSM_IDLE: begin
                if (acc) begin
                    mode_next     = dec_mode;
                    walk_idx_next = '0;
                    best_next     = '0;
                    best_pr_next  = WORST_PRIO;
                    bit_next      = in_bit;
                    granted_next  = dec_grant;
                    lock_next     = dec_lock;
                    if (op == OP_START) cur_next = '0;
                    if (dec_wm_clear) begin
                        tbl_we_wm = 1'b1;
                        wr_wm     = rd_wm & ~in_bit;
                    end
                end
            end
            FSM_WALK: begin
                tbl_we_state  = 1'b1;
                tbl_we_cd     = 1'b1;
                tbl_we_wm     = 1'b1;
                walk_idx_next = walk_idx_reg + IW'(1);
                if (st_cand) begin
                    best_next    = walk_idx_reg;
                    best_pr_next = w_prio;
                end
            end
            FSM_COMMIT: begin
                tbl_we_state = 1'b1;
                wr_state     = TS_RUNNING;
                cur_next     = best_reg;
            end
            FSM_DONE: begin
                if (out_free) begin
                    m_valid_next        = 1'b1;
                    m_running_task_next = 2'(cur_reg);
                    m_granted_next      = granted_reg;
                    m_mutexes_held_next = 8'(64'(lock_reg));
                end
            end
            default: ;
        endcase
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fsm_reg     <= FSM_IDLE;
            m_valid_reg <= 1'b0;
            lock_reg    <= '0;
            cur_reg     <= '0;
            for (int i = 0; i < TASKS; i++) begin
                ts_reg[i] <= TS_DONE;
                cd_reg[i] <= '0;
                wm_reg[i] <= '0;
            end
        end else begin
            fsm_reg     <= fsm_next;
            m_valid_reg <= m_valid_next;
            lock_reg    <= lock_next;
            cur_reg     <= cur_next;
            if (tbl_we_state) ts_reg[tbl_addr] <= wr_state;
            if (tbl_we_cd)    cd_reg[tbl_addr] <= wr_cd;
            if (tbl_we_wm)    wm_reg[tbl_addr] <= wr_wm;
        end
    end

    always_ff @(posedge aclk) begin
        mode_reg           <= mode_next;
        walk_idx_reg       <= walk_idx_next;
        best_reg           <= best_next;
        best_pr_reg        <= best_pr_next;
        bit_reg            <= bit_next;
        granted_reg        <= granted_next;
        m_running_task_reg <= m_running_task_next;
        m_granted_reg      <= m_granted_next;
        m_mutexes_held_reg <= m_mutexes_held_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_running_task = m_running_task_reg;
    assign m_granted      = m_granted_reg;
    assign m_mutexes_held = m_mutexes_held_reg;

endmodule

// ===== sim/testbench.sv =====
// ============================================================================
// testbench
// Self-checking bench for the fixed-priority task scheduler: directed event
// sequences, then randomized scheduling phases, checked item by item against
// a behavioral model of the task table, mutex bits and rescheduling.
// ============================================================================
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import fpts_pkg::*;

    localparam int unsigned TASKS   = 4;
    localparam int unsigned MUTEXES = 8;

    // one result item as the block should report it
    typedef struct {
        logic [1:0] running;
        logic       granted;
        logic [7:0] held;
    } sched_result_t;

    // ------------------------------------------------------------------
    // clock and DUT signals; every input starts at a known value
    // ------------------------------------------------------------------
    logic              aclk          = 1'b0;
    logic              aresetn       = 1'b0;
    logic              psel          = 1'b0;
    logic              penable       = 1'b0;
    logic              pwrite        = 1'b0;
    logic [ADDR_W-1:0] paddr         = '0;
    logic [CFG_W-1:0]  pwdata        = '0;
    logic [CFG_W-1:0]  prdata;
    logic              pready;
    logic              s_valid       = 1'b0;
    logic              s_ready;
    logic [2:0]        s_op          = '0;
    logic [7:0]        s_mutex_index = '0;
    logic              m_valid;
    logic              m_ready       = 1'b0;
    logic [1:0]        m_running_task;
    logic              m_granted;
    logic [7:0]        m_mutexes_held;

    always #2 aclk = ~aclk;

    fixed_priority_task_scheduler_unit #(
        .TASKS   (TASKS),
        .MUTEXES (MUTEXES)
    ) u_top (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_op           (s_op),
        .s_mutex_index  (s_mutex_index),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_running_task (m_running_task),
        .m_granted      (m_granted),
        .m_mutexes_held (m_mutexes_held)
    );

    // ------------------------------------------------------------------
    // bench bookkeeping
    // ------------------------------------------------------------------
    sched_result_t pending_schedules[$];  // expected results, oldest first
    int unsigned   fail_count  = 0;
    int unsigned   events_sent = 0;
    bit            idling_on   = 1'b1;    // random gaps on both channels
    int unsigned   rx_hold_len = 0;       // long receiver stall request

    // ------------------------------------------------------------------
    // scheduler model: our own copy of configuration and task table
    // ------------------------------------------------------------------
    logic [2:0]   cfg_active;
    logic [31:0]  cfg_prio;
    logic [63:0]  cfg_periods;
    logic [63:0]  cfg_delays;

    task_state_t  sched_state[TASKS];
    logic [15:0]  sched_countdown[TASKS];
    logic [7:0]   sched_wait[TASKS];
    logic [7:0]   sched_locks;
    logic [1:0]   sched_current;

    function automatic void reset_schedule_model();
        cfg_active  = 3'd1;
        cfg_prio    = 32'hFFFF_FFFF;
        cfg_periods = '0;
        cfg_delays  = '0;
        for (int i = 0; i < TASKS; i++) begin
            sched_state[i]     = TS_DONE;
            sched_countdown[i] = '0;
            sched_wait[i]      = '0;
        end
        sched_locks   = '0;
        sched_current = '0;
    endfunction

    // active_tasks above TASKS saturates; zero walks nothing
    function automatic int unsigned walked_tasks();
        return (cfg_active > TASKS) ? TASKS : int'(cfg_active);
    endfunction

    // lowest priority value among ready/waiting tasks with free mutexes,
    // ties go to the higher index, task 0 by default
    function automatic void pick_next_task();
        int unsigned n;
        int unsigned best;
        logic [7:0]  best_pr;
        logic [7:0]  pr;
        n       = walked_tasks();
        best    = 0;
        best_pr = WORST_PRIO;
        if (sched_state[sched_current] == TS_RUNNING)
            sched_state[sched_current] = TS_WAITING;
        for (int i = 0; i < n; i++) begin
            pr = cfg_prio[8*i +: 8];
            if (pr <= best_pr &&
                (sched_state[i] == TS_READY || sched_state[i] == TS_WAITING) &&
                (sched_wait[i] & sched_locks) == 8'd0) begin
                best    = i;
                best_pr = pr;
            end
        end
        sched_current     = best[1:0];
        sched_state[best] = TS_RUNNING;
    endfunction

    // tick: expired countdowns reload and release their task; dead skipped
    function automatic void advance_countdowns();
        int unsigned n;
        n = walked_tasks();
        for (int i = 0; i < n; i++) begin
            if (sched_state[i] != TS_DEAD) begin
                if (sched_countdown[i] == 16'd0) begin
                    sched_state[i]     = TS_READY;
                    sched_countdown[i] = cfg_periods[16*i +: 16];
                end
                if (sched_countdown[i] != 16'd0)
                    sched_countdown[i] = sched_countdown[i] - 16'd1;
            end
        end
    endfunction

    function automatic sched_result_t next_schedule(input op_t op, input logic [7:0] idx);
        sched_result_t r;
        logic          in_range;
        logic [7:0]    bit_m;
        logic [1:0]    cur;
        in_range  = (idx < MUTEXES);
        bit_m     = in_range ? (8'd1 << idx[2:0]) : 8'd0;
        cur       = sched_current;
        r.granted = 1'b0;
        case (op)
            OP_TICK: begin
                advance_countdowns();
                pick_next_task();
            end
            OP_YIELD: begin
                sched_state[cur] = TS_WAITING;
                pick_next_task();
            end
            OP_SUSPEND: begin
                sched_state[cur] = TS_DONE;
                pick_next_task();
            end
            OP_KILL: begin
                sched_state[cur] = TS_DEAD;
                pick_next_task();
            end
            OP_TRYLOCK: begin
                if (in_range && (sched_locks & bit_m) == 8'd0) begin
                    sched_locks = sched_locks | bit_m;
                    r.granted   = 1'b1;
                end
            end
            OP_LOCK: begin
                if (in_range) begin
                    if ((sched_locks & bit_m) != 8'd0) begin
                        // held: block on it and hand the CPU on
                        sched_wait[cur]  = sched_wait[cur] | bit_m;
                        sched_state[cur] = TS_WAITING;
                        pick_next_task();
                    end else begin
                        sched_wait[cur] = sched_wait[cur] & ~bit_m;
                        sched_locks     = sched_locks | bit_m;
                        r.granted       = 1'b1;
                    end
                end
            end
            OP_UNLOCK: begin
                if (in_range)
                    sched_locks = sched_locks & ~bit_m;
            end
            default: begin
                // start: reload countdowns, everything done, locks free
                for (int i = 0; i < TASKS; i++) begin
                    sched_countdown[i] = cfg_delays[16*i +: 16];
                    sched_state[i]     = TS_DONE;
                    sched_wait[i]      = '0;
                end
                sched_locks   = '0;
                sched_current = '0;
            end
        endcase
        r.running = sched_current;
        r.held    = sched_locks;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // sender: one item per call, valid held across back-to-back items
    // ------------------------------------------------------------------
    task automatic send_event(input op_t op, input logic [7:0] idx);
        int unsigned gap;
        gap = 0;
        if (idling_on && $urandom_range(0, 4) == 0)
            gap = $urandom_range(1, 9);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_op          <= op;
        s_mutex_index <= idx;
        do @(posedge aclk); while (!s_ready);
        pending_schedules.push_back(next_schedule(op, idx));
        events_sent++;
    endtask

    // drop valid, let every result drain, then cover the longest walk
    task automatic wait_quiet();
        s_valid <= 1'b0;
        while (pending_schedules.size() != 0) @(posedge aclk);
        repeat (TASKS + 8) @(posedge aclk);
    endtask

    // APB write: setup, access; register taken at the access edge
    task automatic write_reg(input reg_addr_t which, input logic [63:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {which, 3'b000};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
        case (which)
            REG_ACTIVE_TASKS: cfg_active  = value[2:0];
            REG_PRIORITIES:   cfg_prio    = value[31:0];
            REG_PERIODS:      cfg_periods = value;
            default:          cfg_delays  = value;
        endcase
    endtask

    task automatic configure(input logic [2:0] active, input logic [31:0] prio,
                             input logic [63:0] periods, input logic [63:0] delays);
        wait_quiet();
        write_reg(REG_ACTIVE_TASKS, {61'd0, active});
        write_reg(REG_PRIORITIES,   {32'd0, prio});
        write_reg(REG_PERIODS,      periods);
        write_reg(REG_START_DELAYS, delays);
    endtask

    // ------------------------------------------------------------------
    // random helpers
    // ------------------------------------------------------------------
    function automatic logic [7:0] pick_mutex();
        return ($urandom_range(0, 99) < 85) ? 8'($urandom_range(0, 7))
                                            : 8'($urandom_range(0, 255));
    endfunction

    // mostly short periods so tasks wake often; now and then full range
    function automatic logic [63:0] pick_counts();
        logic [63:0] v;
        if ($urandom_range(0, 4) == 0) begin
            v = {$urandom, $urandom};
        end else begin
            for (int i = 0; i < 4; i++)
                v[16*i +: 16] = 16'($urandom_range(0, 6));
        end
        return v;
    endfunction

    function automatic logic [31:0] pick_priorities();
        logic [31:0] v;
        if ($urandom_range(0, 1) == 0) begin
            v = $urandom;
        end else begin
            // narrow range forces ties
            for (int i = 0; i < 4; i++)
                v[8*i +: 8] = 8'($urandom_range(0, 3));
        end
        return v;
    endfunction

    function automatic logic [2:0] pick_active();
        return ($urandom_range(0, 7) != 0) ? 3'($urandom_range(1, 4))
                                           : 3'($urandom_range(0, 7));
    endfunction

    // well-formed scheduling traffic with some noise mixed in
    task automatic run_traffic(input int unsigned count);
        int unsigned target;
        int unsigned pick;
        logic [7:0]  m;
        target = events_sent + count;
        while (events_sent < target) begin
            pick = $urandom_range(0, 19);
            m    = pick_mutex();
            if (pick < 7) begin
                send_event(OP_TICK, 8'($urandom));
            end else if (pick < 11) begin
                // critical section: lock, some work, release
                send_event(OP_LOCK, m);
                if ($urandom_range(0, 1) == 0) send_event(OP_TICK, 8'd0);
                if ($urandom_range(0, 2) == 0) send_event(OP_YIELD, 8'd0);
                send_event(OP_UNLOCK, m);
            end else if (pick < 13) begin
                send_event(OP_TRYLOCK, m);
                if ($urandom_range(0, 2) != 0) send_event(OP_UNLOCK, m);
            end else if (pick < 15) begin
                send_event(OP_YIELD, 8'($urandom));
            end else if (pick == 15) begin
                send_event(OP_SUSPEND, 8'($urandom));
            end else if (pick == 16) begin
                send_event(($urandom_range(0, 3) == 0) ? OP_KILL : OP_LOCK, m);
            end else if (pick == 17) begin
                send_event(OP_UNLOCK, 8'($urandom));
            end else if (pick == 18) begin
                // noise: any op with any index
                send_event(op_t'($urandom_range(0, 7)), 8'($urandom));
            end else begin
                if ($urandom_range(0, 3) == 0) send_event(OP_START, 8'($urandom));
                else send_event(OP_TICK, 8'd255);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // receiver: random stall bursts, plus one long hold when requested
    // ------------------------------------------------------------------
    initial begin
        wait (aresetn);
        forever begin
            @(posedge aclk);
            if (rx_hold_len != 0) begin
                m_ready <= 1'b0;
                repeat (rx_hold_len) @(posedge aclk);
                rx_hold_len = 0;
                m_ready <= 1'b1;
            end else if (idling_on && $urandom_range(0, 5) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge aclk);
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // result check: every accepted item against the oldest expectation
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : result_check
        sched_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_schedules.size() == 0) begin
                $display("%0t: result item with none expected (task %0d)",
                         $realtime, m_running_task);
                fail_count++;
            end else begin
                want = pending_schedules.pop_front();
                if (m_running_task !== want.running) begin
                    $display("%0t: running_task expected %0d actual %0d",
                             $realtime, want.running, m_running_task);
                    fail_count++;
                end
                if (m_granted !== want.granted) begin
                    $display("%0t: granted expected %0d actual %0d",
                             $realtime, want.granted, m_granted);
                    fail_count++;
                end
                if (m_mutexes_held !== want.held) begin
                    $display("%0t: mutexes_held expected %h actual %h",
                             $realtime, want.held, m_mutexes_held);
                    fail_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // reset config: only task 0 walked, all priorities worst
    task automatic test_reset_defaults();
        send_event(OP_TICK,    8'd0);
        send_event(OP_YIELD,   8'd0);
        send_event(OP_TRYLOCK, 8'd0);
        send_event(OP_LOCK,    8'd0);     // held: blocks, idle task resumes
        send_event(OP_UNLOCK,  8'd0);
        send_event(OP_UNLOCK,  8'd0);     // already free
        send_event(OP_TRYLOCK, 8'd255);   // out of range, rejected
        send_event(OP_LOCK,    8'd8);
        send_event(OP_UNLOCK,  8'd200);
        send_event(OP_SUSPEND, 8'd0);
        send_event(OP_KILL,    8'd0);
        send_event(OP_START,   8'd0);
    endtask

    // four tasks, tied priorities, blocking lock hand-off and preemption
    task automatic test_lock_and_preemption();
        configure(3'd4, {8'd1, 8'd2, 8'd2, 8'd255}, 64'd0, 64'h0001_0000_0002_0000);
        send_event(OP_START,   8'd0);
        send_event(OP_TICK,    8'd0);     // task 2 runs; task 3 not yet released
        send_event(OP_LOCK,    8'd3);
        send_event(OP_YIELD,   8'd0);     // still most urgent, runs again
        send_event(OP_SUSPEND, 8'd0);     // task 0 is the only one left ready
        send_event(OP_LOCK,    8'd3);     // task 0 blocks on mutex 3
        send_event(OP_UNLOCK,  8'd3);
        send_event(OP_TICK,    8'd0);
        send_event(OP_KILL,    8'd0);     // dead task skipped from now on
        send_event(OP_LOCK,    8'd3);
        send_event(OP_TICK,    8'd0);
        send_event(OP_TRYLOCK, 8'd3);     // held, not granted
        send_event(OP_TRYLOCK, 8'd7);
        send_event(OP_LOCK,    8'd255);
    endtask

    // task counts of zero and above the table size
    task automatic test_task_count_limits();
        configure(3'd0, 32'h0000_0000, 64'd0, 64'd0);
        send_event(OP_START, 8'd0);
        send_event(OP_TICK,  8'd0);       // nothing walked: default task 0
        configure(3'd7, 32'h0102_0304, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
        send_event(OP_START, 8'd0);
        send_event(OP_TICK,  8'd0);
        send_event(OP_YIELD, 8'd0);
    endtask

    // randomized phases, extremes of the configuration first
    task automatic test_random_phases();
        for (int p = 0; p < 16; p++) begin
            case (p)
                0:       configure(3'd4, 32'h0000_0000, 64'd0, 64'd0);
                1:       configure(3'd4, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
                                   64'hFFFF_FFFF_FFFF_FFFF);
                2:       configure(3'd1, 32'hFFFF_FF00, 64'd1, 64'd0);
                default: configure(pick_active(), pick_priorities(), pick_counts(),
                                   pick_counts());
            endcase
            send_event(OP_START, 8'($urandom));
            run_traffic(105);
        end
    endtask

    // long result stall while events keep coming: input must back up
    task automatic test_output_backpressure();
        configure(3'd4, 32'h0302_0100, 64'h0002_0001_0003_0000, 64'd0);
        send_event(OP_START, 8'd0);
        rx_hold_len = 300;
        run_traffic(30);
    endtask

    // final stretch with both channels running flat out
    task automatic test_no_idle_tail();
        wait_quiet();
        idling_on = 1'b0;
        configure(3'd4, pick_priorities(), pick_counts(), pick_counts());
        send_event(OP_START, 8'd0);
        run_traffic(150);
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin
        reset_schedule_model();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_defaults();
        test_lock_and_preemption();
        test_task_count_limits();
        test_random_phases();
        test_output_backpressure();
        test_no_idle_tail();

        wait_quiet();
        if (fail_count == 0 && pending_schedules.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial begin
        #2000000;
        $display("watchdog expired, %0d results outstanding", pending_schedules.size());
        $display("== FAIL ==");
        $finish;
    end

endmodule
